FILE: rtl/vnt_pkg.sv
`default_nettype none
package vnt_pkg;

   localparam int CH_W       = 16;
   localparam int CHANNELS   = 3;
   localparam int COLOR_W    = 48;
   localparam int OCT_FLD_W  = 64;
   localparam int COORD_W    = 32;
   localparam int FREQ_W     = 16;
   localparam int PROD_W     = 48;
   localparam int HASH_W     = 32;
   localparam int CORNERS    = 8;
   localparam int CORNER_W   = 3;
   localparam int OCT_IDX_W  = 2;
   localparam int ACC_W      = 34;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int CNT_W      = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_WHITE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLACK = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQS = 3'd4;

   localparam logic [COLOR_W-1:0]   WHITE_RST = 48'h1000_1000_1000;
   localparam logic [CNT_W-1:0]     COUNT_RST = 3'd1;
   localparam logic [OCT_FLD_W-1:0] AMPS_RST  = 64'h1000;
   localparam logic [OCT_FLD_W-1:0] FREQS_RST = 64'h0100;

   localparam logic [HASH_W-1:0] HASH_Y   = 32'd57;
   localparam logic [HASH_W-1:0] HASH_Z   = 32'd997;
   localparam logic [HASH_W-1:0] HASH_MUL = 32'd15731;
   localparam logic [HASH_W-1:0] HASH_ADD = 32'd789221;
   localparam logic [HASH_W-1:0] HASH_OFS = 32'd1376312589;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCALE, ST_ISSUE, ST_DRAIN, ST_LERP_X, ST_LERP_Y,
      ST_LERP_Z, ST_AMP, ST_ACC, ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 load_point;
      logic                 acc_clear;
      logic                 scale;
      logic                 issue;
      logic [CORNER_W-1:0]  corner;
      logic                 lerp_x;
      logic                 lerp_y;
      logic                 lerp_z;
      logic                 amp_mul;
      logic                 acc_add;
      logic                 out_load;
      logic [OCT_IDX_W-1:0] oct_idx;
   } cmd_type;

   typedef struct packed {
      logic hash_idle;
      logic out_free;
   } status_type;

   // (a*(1-t) + b*t), Q0.16 weight, truncated
   function automatic logic [CH_W-1:0] lerp16(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b,
                                              input logic [FRAC_W-1:0] t);
      logic [FRAC_W:0]   tc;
      logic [32:0]       p0;
      logic [32:0]       p1;
      logic [33:0]       s;
      tc = 17'h10000 - {1'b0, t};
      p0 = 33'(a) * 33'(tc);
      p1 = 33'(b) * 33'(t);
      s  = {1'b0, p0} + {1'b0, p1};
      return s[31:16];
   endfunction

   // black*(1-w) + white*w with w in Q0.31
   function automatic logic [CH_W-1:0] corner_mix(input logic [CH_W-1:0] bl,
                                                  input logic [CH_W-1:0] wh,
                                                  input logic [30:0] w);
      logic [31:0] inv;
      logic [47:0] p0;
      logic [47:0] p1;
      logic [48:0] s;
      inv = 32'h8000_0000 - {1'b0, w};
      p0  = 48'(bl) * 48'(inv);
      p1  = 48'(wh) * 48'(w);
      s   = {1'b0, p0} + {1'b0, p1};
      return s[46:31];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/vnt_ctrl.sv
`default_nettype none
module vnt_ctrl
   import vnt_pkg::*;
#(
   parameter int MAX_OCTAVES = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [CNT_W-1:0] octave_count,
   input  wire status_type       status,
   output logic                  req_stall,
   output cmd_type               cmd
);

   localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

   state_type           state_ff, state_in;
   logic [OCT_W-1:0]    oct_ff, oct_in;
   logic [CORNER_W-1:0] corner_ff, corner_in;
   logic [OCT_W-1:0]    count;
   logic                last_oct;

   assign count = (octave_count > CNT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES)
                                                       : OCT_W'(octave_count);
   assign last_oct = (OCT_W'(oct_ff + 1'b1) == count);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         oct_ff    <= '0;
         corner_ff <= '0;
      end else begin
         state_ff  <= state_in;
         oct_ff    <= oct_in;
         corner_ff <= corner_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      oct_in      = oct_ff;
      corner_in   = corner_ff;
      req_stall   = 1'b1;
      cmd         = '0;
      cmd.corner  = corner_ff;
      cmd.oct_idx = OCT_IDX_W'(oct_ff);
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_point = 1'b1;
               cmd.acc_clear  = 1'b1;
               oct_in         = '0;
               state_in       = (count == '0) ? ST_FINISH : ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            corner_in = '0;
            state_in  = ST_ISSUE;
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            corner_in = corner_ff + 1'b1;
            if (corner_ff == CORNER_W'(CORNERS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.hash_idle) begin
               state_in = ST_LERP_X;
            end
         end
         ST_LERP_X: begin
            cmd.lerp_x = 1'b1;
            state_in   = ST_LERP_Y;
         end
         ST_LERP_Y: begin
            cmd.lerp_y = 1'b1;
            state_in   = ST_LERP_Z;
         end
         ST_LERP_Z: begin
            cmd.lerp_z = 1'b1;
            state_in   = ST_AMP;
         end
         ST_AMP: begin
            cmd.amp_mul = 1'b1;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_add = 1'b1;
            if (last_oct) begin
               state_in = ST_FINISH;
            end else begin
               oct_in   = oct_ff + 1'b1;
               state_in = ST_SCALE;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_drain_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && status.hash_idle) |=> state_ff == ST_LERP_X)
      else $error("drain did not advance to interpolation");

   a_clear_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_clear |-> (req_valid && !req_stall))
      else $error("accumulator cleared without accepted transaction");

   a_oct_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scale |-> (oct_ff < count))
      else $error("octave index beyond active count");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == ST_IDLE)
      else $error("result load not followed by idle");

endmodule
`default_nettype wire

FILE: rtl/vnt_datapath.sv
`default_nettype none
module vnt_datapath
   import vnt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output status_type                status,
   input  wire logic [COORD_W-1:0]   req_point_x,
   input  wire logic [COORD_W-1:0]   req_point_y,
   input  wire logic [COORD_W-1:0]   req_point_z,
   input  wire logic [COLOR_W-1:0]   white_color,
   input  wire logic [COLOR_W-1:0]   black_color,
   input  wire logic [OCT_FLD_W-1:0] octave_amplitudes,
   input  wire logic [OCT_FLD_W-1:0] octave_frequencies,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output logic [CH_W-1:0]           rsp_red,
   output logic [CH_W-1:0]           rsp_green,
   output logic [CH_W-1:0]           rsp_blue,
   output logic                      rsp_saturated
);

   logic signed [COORD_W-1:0] pt_ff [3];
   logic signed [PROD_W-1:0]  p_ff  [3];
   logic signed [FREQ_W:0]    freq_s;
   logic [FREQ_W-1:0]         amp;
   logic [HASH_W-1:0]         lat   [3];
   logic [FRAC_W-1:0]         frac  [3];

   logic [HASH_W-1:0]   cx, cy, cz, n0, n1;
   logic                a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff;
   logic [HASH_W-1:0]   a_n_ff, b_n_ff, c_n_ff;
   logic [HASH_W-1:0]   b_sq_ff, c_m_ff, d_m;
   logic [30:0]         d_w_ff;
   logic [CORNER_W-1:0] a_c_ff, b_c_ff, c_c_ff, d_c_ff;

   logic [CH_W-1:0]  col_ff [CORNERS][CHANNELS];
   logic [CH_W-1:0]  lx_ff  [CHANNELS][4];
   logic [CH_W-1:0]  ly_ff  [CHANNELS][2];
   logic [CH_W-1:0]  lz_ff  [CHANNELS];
   logic [31:0]      pr_ff  [CHANNELS];
   logic [ACC_W-1:0] acc_ff [CHANNELS];
   logic [CH_W-1:0]  res    [CHANNELS];
   logic [CHANNELS-1:0] over;

   logic            rsp_valid_ff;
   logic [CH_W-1:0] rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic            rsp_s_ff;

   assign freq_s = signed'({1'b0, octave_frequencies[{cmd.oct_idx, 4'b0} +: FREQ_W]});
   assign amp    = octave_amplitudes[{cmd.oct_idx, 4'b0} +: CH_W];

   // floor cell and Q0.16 fraction of each scaled coordinate
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         lat[a]  = {{8{p_ff[a][PROD_W-1]}}, p_ff[a][PROD_W-1:24]};
         frac[a] = p_ff[a][23:8];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_point) begin
         pt_ff[0] <= signed'(req_point_x);
         pt_ff[1] <= signed'(req_point_y);
         pt_ff[2] <= signed'(req_point_z);
      end
      if (cmd.scale) begin
         for (int a = 0; a < 3; a++) begin
            p_ff[a] <= PROD_W'(pt_ff[a]) * PROD_W'(freq_s);
         end
      end
   end

   // hash input for one corner
   assign cx = lat[0] + HASH_W'(cmd.corner[0]);
   assign cy = lat[1] + HASH_W'(cmd.corner[1]);
   assign cz = lat[2] + HASH_W'(cmd.corner[2]);
   assign n0 = cx + cy * HASH_Y + cz * HASH_Z;
   assign n1 = (n0 << 13) ^ n0;
   assign d_m = c_n_ff * c_m_ff + HASH_OFS;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= cmd.issue;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_n_ff  <= n1;
      a_c_ff  <= cmd.corner;
      b_sq_ff <= a_n_ff * a_n_ff;
      b_n_ff  <= a_n_ff;
      b_c_ff  <= a_c_ff;
      c_m_ff  <= b_sq_ff * HASH_MUL + HASH_ADD;
      c_n_ff  <= b_n_ff;
      c_c_ff  <= b_c_ff;
      d_w_ff  <= d_m[30:0];
      d_c_ff  <= c_c_ff;
      if (d_vld_ff) begin
         for (int k = 0; k < CHANNELS; k++) begin
            col_ff[d_c_ff][k] <= corner_mix(black_color[16*k +: CH_W],
                                            white_color[16*k +: CH_W], d_w_ff);
         end
      end
   end

   assign status.hash_idle = !(a_vld_ff || b_vld_ff || c_vld_ff || d_vld_ff);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      for (int k = 0; k < CHANNELS; k++) begin
         if (cmd.lerp_x) begin
            for (int j = 0; j < 4; j++) begin
               lx_ff[k][j] <= lerp16(col_ff[2*j][k], col_ff[2*j+1][k], frac[0]);
            end
         end
         if (cmd.lerp_y) begin
            ly_ff[k][0] <= lerp16(lx_ff[k][0], lx_ff[k][1], frac[1]);
            ly_ff[k][1] <= lerp16(lx_ff[k][2], lx_ff[k][3], frac[1]);
         end
         if (cmd.lerp_z) begin
            lz_ff[k] <= lerp16(ly_ff[k][0], ly_ff[k][1], frac[2]);
         end
         if (cmd.amp_mul) begin
            pr_ff[k] <= 32'(lz_ff[k]) * 32'(amp);
         end
         if (cmd.acc_clear) begin
            acc_ff[k] <= '0;
         end else if (cmd.acc_add) begin
            acc_ff[k] <= acc_ff[k] + ACC_W'(pr_ff[k]);
         end
      end
   end

   // drop the low 12 bits, clamp to the channel range
   always_comb begin
      for (int k = 0; k < CHANNELS; k++) begin
         over[k] = |acc_ff[k][ACC_W-1:28];
         res[k]  = over[k] ? {CH_W{1'b1}} : acc_ff[k][27:12];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_r_ff <= res[0];
         rsp_g_ff <= res[1];
         rsp_b_ff <= res[2];
         rsp_s_ff <= |over;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red       = rsp_r_ff;
   assign rsp_green     = rsp_g_ff;
   assign rsp_blue      = rsp_b_ff;
   assign rsp_saturated = rsp_s_ff;

endmodule
`default_nettype wire

FILE: rtl/value_noise_texture_trilinear_top.sv
// Value-noise texture: one 3D point in, one RGB color out.
// Request channel: req_valid / req_stall with req_point_x/y/z (signed Q16.16).
// A transaction is taken when req_valid is high and req_stall is low.
// Response channel: rsp_valid / rsp_stall with rsp_red/green/blue (Q4.12)
// and rsp_saturated, set when any channel was clamped to full scale.
// Configuration: csr_wr_en writes csr_wr_data into register csr_index
// (0 white, 1 black, 2 octave count, 3 amplitudes, 4 frequencies);
// write only while the block is idle. Unknown indexes are ignored.
// Zero octaves skip the octave steps and return all-zero channels.
// Per octave: a scaling step, 8 corner issues into the shared 4-stage
// hash pipeline, a drain until that pipeline is empty, 3 interpolation
// levels, the amplitude multiply and the accumulate. One point is in
// flight at a time; a new point is taken only once the last has finished.
// The finished color sits in the response register, so the next point
// is taken while it waits; a stalled receiver holds the result and only
// blocks completion of the following point.
// Reset: synchronous, returns to idle, clears response valid and loads
// the register defaults (white 1.0, black 0, one octave, unit gains).
`default_nettype none
module value_noise_texture_trilinear_top
   import vnt_pkg::*;
#(
   parameter int MAX_OCTAVES = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [COORD_W-1:0]    req_point_x,
   input  wire logic [COORD_W-1:0]    req_point_y,
   input  wire logic [COORD_W-1:0]    req_point_z,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [CH_W-1:0]            rsp_red,
   output logic [CH_W-1:0]            rsp_green,
   output logic [CH_W-1:0]            rsp_blue,
   output logic                       rsp_saturated,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic [COLOR_W-1:0]   white_ff;
   logic [COLOR_W-1:0]   black_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [OCT_FLD_W-1:0] amps_ff;
   logic [OCT_FLD_W-1:0] freqs_ff;

   cmd_type    cmd;
   status_type status;

   // configuration registers; hold unless written
   always_ff @(posedge clock) begin
      if (reset) begin
         white_ff <= WHITE_RST;
         black_ff <= '0;
         count_ff <= COUNT_RST;
         amps_ff  <= AMPS_RST;
         freqs_ff <= FREQS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WHITE: white_ff <= csr_wr_data[COLOR_W-1:0];
            CSR_BLACK: black_ff <= csr_wr_data[COLOR_W-1:0];
            CSR_COUNT: count_ff <= csr_wr_data[CNT_W-1:0];
            CSR_AMPS:  amps_ff  <= csr_wr_data;
            CSR_FREQS: freqs_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // sequencer: walks octaves and corners
   vnt_ctrl #(
      .MAX_OCTAVES (MAX_OCTAVES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .octave_count (count_ff),
      .status       (status),
      .req_stall    (req_stall),
      .cmd          (cmd)
   );

   // arithmetic: scaling, hash pipeline, interpolation, accumulation
   vnt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_point_z        (req_point_z),
      .white_color        (white_ff),
      .black_color        (black_ff),
      .octave_amplitudes  (amps_ff),
      .octave_frequencies (freqs_ff),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_saturated      (rsp_saturated)
   );

endmodule
`default_nettype wire

FILE: sim/value_noise_texture_trilinear_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module value_noise_texture_trilinear_top_tb;
   import vnt_pkg::*;

   // Register indexes not covered by the package.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int IDLE_LIMIT = 20000;
   localparam int NUM_RANDOM = 1030;
   localparam int NUM_DIRECTED = 12;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            saturated;
   } color_type;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               known;   // expected color typed in below
      color_type          color;
   } point_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [COORD_W-1:0] req_point_x = '0;
   logic [COORD_W-1:0] req_point_y = '0;
   logic [COORD_W-1:0] req_point_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CH_W-1:0] rsp_red;
   logic [CH_W-1:0] rsp_green;
   logic [CH_W-1:0] rsp_blue;
   logic rsp_saturated;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // Local copy of the texture settings.
   logic [COLOR_W-1:0]   tex_white;
   logic [COLOR_W-1:0]   tex_black;
   logic [CNT_W-1:0]     tex_octaves;
   logic [OCT_FLD_W-1:0] tex_amps;
   logic [OCT_FLD_W-1:0] tex_freqs;

   color_type     pending_colors[$];
   point_row_type point_table[NUM_DIRECTED];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  drain_done = 1'b0;
   bit  hold_rsp = 1'b0;   // long receiver hold-off request

   always #5 clock = ~clock;

   value_noise_texture_trilinear_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(req_point_x), .req_point_y(req_point_y), .req_point_z(req_point_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .rsp_saturated(rsp_saturated),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   function automatic logic [30:0] lattice_weight(input logic [31:0] cx,
                                                  input logic [31:0] cy,
                                                  input logic [31:0] cz);
      logic [31:0] n;
      n = cx + cy * 32'd57 + cz * 32'd997;
      n = (n << 13) ^ n;
      n = n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589;
      return n[30:0];
   endfunction

   function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] t);
      logic [63:0] s;
      s = 64'(a) * (64'd65536 - 64'(t)) + 64'(b) * 64'(t);
      return s[31:16];
   endfunction

   // Sum all active octaves of the noise at one point.
   function automatic color_type texture_color(input logic [31:0] px, input logic [31:0] py,
                                               input logic [31:0] pz);
      logic [63:0]  acc[3];
      logic signed [63:0] prod;
      logic signed [63:0] lat[3];
      logic [15:0]  t[3];
      logic [30:0]  w[8];
      logic [31:0]  pt[3];
      logic [15:0]  col[8];
      logic [15:0]  wh, bl, freq, amp, y0, y1;
      logic [63:0]  mix, v;
      int count;
      color_type r;
      pt[0] = px; pt[1] = py; pt[2] = pz;
      acc[0] = 0; acc[1] = 0; acc[2] = 0;
      count = (tex_octaves > 4) ? 4 : tex_octaves;
      for (int o = 0; o < count; o++) begin
         freq = tex_freqs[16*o +: 16];
         amp  = tex_amps[16*o +: 16];
         for (int a = 0; a < 3; a++) begin
            prod = $signed({{32{pt[a][31]}}, pt[a]}) * $signed({48'd0, freq});
            lat[a] = prod >>> 24;   // arithmetic shift is a true floor
            t[a] = prod[23:8];
         end
         for (int c = 0; c < 8; c++)
            w[c] = lattice_weight(lat[0][31:0] + c[0], lat[1][31:0] + c[1],
                                  lat[2][31:0] + c[2]);
         for (int k = 0; k < 3; k++) begin
            wh = tex_white[16*k +: 16];
            bl = tex_black[16*k +: 16];
            for (int c = 0; c < 8; c++) begin
               mix = 64'(bl) * (64'h8000_0000 - 64'(w[c])) + 64'(wh) * 64'(w[c]);
               col[c] = mix[46:31];
            end
            y0 = blend(blend(col[0], col[1], t[0]), blend(col[2], col[3], t[0]), t[1]);
            y1 = blend(blend(col[4], col[5], t[0]), blend(col[6], col[7], t[0]), t[1]);
            acc[k] += 64'(blend(y0, y1, t[2])) * 64'(amp);
         end
      end
      r.saturated = 1'b0;
      for (int k = 0; k < 3; k++) begin
         v = acc[k] >> 12;
         if (v > 64'hFFFF) begin
            v = 64'hFFFF;
            r.saturated = 1'b1;
         end
         case (k)
            0: r.red = v[15:0];
            1: r.green = v[15:0];
            default: r.blue = v[15:0];
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_WHITE: tex_white = data[COLOR_W-1:0];
         CSR_BLACK: tex_black = data[COLOR_W-1:0];
         CSR_COUNT: tex_octaves = data[CNT_W-1:0];
         CSR_AMPS:  tex_amps = data;
         CSR_FREQS: tex_freqs = data;
         default: ;
      endcase
   endtask

   // Send one point; queue its expected color once it is taken.
   // Valid stays up after the accept so a zero gap gives back-to-back points.
   task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                             input logic known, input color_type typed);
      int gap;
      color_type want;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (req_stall);
      want = known ? typed : texture_color(x, y, z);
      pending_colors = {pending_colors, want};
   endtask

   // Drop the request, let every expected color come back, then settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return {12'h0, 20'($urandom_range(0, 20'hFFFFF))};
         2: return -$urandom_range(0, 32'h000F_FFFF);
         3: return {16'($urandom_range(0, 16'hFFFF)), 16'h0};  // exact integers
         default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom())};
      endcase
   endfunction

   task automatic random_phase(input int n);
      color_type none;
      none = '0;
      for (int i = 0; i < n; i++)
         send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, none);
      wait_idle();
   endtask

   // Receiver: random stall per transaction, plus one long hold-off.
   initial begin : receiver
      int gap;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rsp_valid && !rsp_stall) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Check each response against the oldest expectation.
   always @(posedge clock) begin
      color_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_red, rsp_green, rsp_blue, rsp_saturated};
         if (pending_colors.size() == 0)
            report_mismatch("response with nothing expected");
         else begin
            want = pending_colors.pop_front();
            if (got.red != want.red)
               report_mismatch($sformatf("red %h exp %h", got.red, want.red));
            if (got.green != want.green)
               report_mismatch($sformatf("green %h exp %h", got.green, want.green));
            if (got.blue != want.blue)
               report_mismatch($sformatf("blue %h exp %h", got.blue, want.blue));
            if (got.saturated != want.saturated)
               report_mismatch($sformatf("saturated %b exp %b", got.saturated,
                                         want.saturated));
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || drain_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout");
         $display("value_noise_texture_trilinear_top: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      color_type none;
      none = '0;
      tex_white = WHITE_RST;
      tex_black = '0;
      tex_octaves = COUNT_RST;
      tex_amps = AMPS_RST;
      tex_freqs = FREQS_RST;

      // Directed points: origin, extremes, exact negatives, fractional offsets.
      point_table[0]  = '{32'h0, 32'h0, 32'h0, 1'b0, none};
      point_table[1]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, none};
      point_table[2]  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, none};
      point_table[3]  = '{32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFD_0000, 1'b0, none};
      point_table[4]  = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_8000, 1'b0, none};
      point_table[5]  = '{32'h0000_8000, 32'h0001_4000, 32'h0002_C000, 1'b0, none};
      point_table[6]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, none};
      point_table[7]  = '{32'h5555_AAAA, 32'hAAAA_5555, 32'h0F0F_F0F0, 1'b0, none};
      point_table[8]  = '{32'h0001_0000, 32'h0, 32'hFFFF_0000, 1'b0, none};
      point_table[9]  = '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_FFFF, 1'b0, none};
      point_table[10] = '{32'h0, 32'h0000_FFFF, 32'h8000_0001, 1'b0, none};
      point_table[11] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings.
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_point(point_table[i].x, point_table[i].y, point_table[i].z,
                    point_table[i].known, point_table[i].color);
      wait_idle();

      // Zero octaves: all-zero channels with no clamp.
      write_reg(CSR_COUNT, 64'd0);
      for (int i = 0; i < 4; i++)
         send_point(point_table[i].x, point_table[i].y, point_table[i].z, 1'b1, none);
      wait_idle();

      // Full-scale colors and gains: forces saturation.
      write_reg(CSR_WHITE, 64'hFFFF_FFFF_FFFF);
      write_reg(CSR_BLACK, 64'hFFFF_FFFF_FFFF);
      write_reg(CSR_COUNT, 64'd7);   // above the maximum: acts as four
      write_reg(CSR_AMPS, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_FREQS, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_UNUSED, 64'h0);  // unknown index: ignored
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_point(point_table[i].x, point_table[i].y, point_table[i].z,
                    1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
      wait_idle();

      // Long receiver hold-off while points keep coming.
      hold_rsp = 1'b1;
      random_phase(30);

      // Random settings across phases, extremes first and last.
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(CSR_WHITE, {$urandom(), $urandom()});
         write_reg(CSR_BLACK, (ph == 1) ? 64'h0 : {$urandom(), $urandom()});
         write_reg(CSR_COUNT, (ph < 5) ? ph : $urandom_range(0, 7));
         write_reg(CSR_AMPS, (ph == 7) ? 64'h0 : {$urandom(), $urandom()} >> $urandom_range(0, 3));
         write_reg(CSR_FREQS, (ph == 2) ? 64'h0001_0001_0001_0001 :
                   {$urandom(), $urandom()} & {4{16'h0FFF}});
         random_phase(125);
      end

      drain_done = 1'b1;
      if (error_count == 0)
         $display("value_noise_texture_trilinear_top: match");
      else
         $display("value_noise_texture_trilinear_top: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
